### hdl/sph_kernel_table_sampler_defines.svh
// assertion macros used by the sampler back pipeline
`ifndef SPH_KERNEL_TABLE_SAMPLER_DEFINES_SVH
`define SPH_KERNEL_TABLE_SAMPLER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SKTS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SKTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/skts_pkg.sv
package skts_pkg;

  // table geometry
  localparam int TABLE_SAMPLES = 1024;
  localparam int IDX_W         = $clog2(TABLE_SAMPLES);
  localparam int LO_W          = IDX_W + 1;
  localparam int POS_W         = 17 + IDX_W;
  localparam int Q_ONE         = 65536;

  // square root pipeline, one result bit per stage
  localparam int SQRT_STEPS = 32;

  // queue between front and back, power of two
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    CMD_EVAL  = 2'd0,
    CMD_WLOAD = 2'd1,
    CMD_GLOAD = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic [9:0]         entry_index;
    logic signed [31:0] entry_value;
  } item_t;

endpackage

### hdl/skts_if.sv
// input item channel
interface skts_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] rx;
  logic signed [31:0] ry;
  logic signed [31:0] rz;
  logic [9:0]         entry_index;
  logic signed [31:0] entry_value;
  modport source (output valid, cmd, rx, ry, rz, entry_index, entry_value, input ready);
  modport sink (input valid, cmd, rx, ry, rz, entry_index, entry_value, output ready);
endinterface

// result channel
interface skts_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] w_value;
  logic signed [31:0] grad_x;
  logic signed [31:0] grad_y;
  logic signed [31:0] grad_z;
  modport source (output valid, w_value, grad_x, grad_y, grad_z, input ready);
  modport sink (input valid, w_value, grad_x, grad_y, grad_z, output ready);
endinterface

// configuration write channel
interface skts_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### hdl/skts_front.sv
module skts_front import skts_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  skts_item_if.sink    items,
  output logic         push_valid,
  input  logic         push_ready,
  output item_t        push_data
);

  logic  fv;
  item_t fit;

  // one holding stage; taken whenever it is empty or drains this cycle
  assign items.ready = !fv || push_ready;
  assign push_valid  = fv;
  assign push_data   = fit;

  // classify: unused commands are dropped at the door
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (items.ready) begin
      fv <= items.valid && (cmd_t'(items.cmd) != CMD_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready) begin
      fit.cmd         <= cmd_t'(items.cmd);
      fit.rx          <= items.rx;
      fit.ry          <= items.ry;
      fit.rz          <= items.rz;
      fit.entry_index <= items.entry_index;
      fit.entry_value <= items.entry_value;
    end
  end

endmodule

### hdl/skts_fifo.sv
module skts_fifo import skts_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_data
);

  item_t            mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [PTR_W:0]   cnt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = cnt != (PTR_W + 1)'(FIFO_DEPTH);
  assign pop_valid  = cnt != '0;
  assign pop_data   = mem[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) wp <= wp + 1'b1;
      if (do_pop) rp <= rp + 1'b1;
      if (do_push && !do_pop) cnt <= cnt + 1'b1;
      else if (do_pop && !do_push) cnt <= cnt - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= push_data;
  end

endmodule

### hdl/skts_back.sv
module skts_back import skts_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        inv_radius,
  input  logic               q_valid,
  output logic               q_ready,
  input  item_t              q_item,
  output logic               o_valid,
  input  logic               o_ready,
  output logic signed [31:0] w_value,
  output logic signed [31:0] grad_x,
  output logic signed [31:0] grad_y,
  output logic signed [31:0] grad_z
);

  `include "sph_kernel_table_sampler_defines.svh"

  logic en;

  // squares
  logic               v1;
  item_t              it1;
  logic signed [63:0] sq0, sq1, sq2;

  // square root stages
  logic        svl [SQRT_STEPS+1];
  item_t       sit [SQRT_STEPS+1];
  logic [63:0] sv  [SQRT_STEPS+1];
  logic [63:0] sr  [SQRT_STEPS+1];

  // radius scale
  logic        vm;
  item_t       itm;
  logic [63:0] prod;

  // position
  logic [47:0]      big;
  logic [POS_W-1:0] pos_c;
  logic             vq;
  item_t            itq;
  logic             inside_q, qz_q;
  logic [LO_W-1:0]  lo_q;
  logic [15:0]      lam_q;
  logic             clamp_q;
  logic [IDX_W-1:0] addr_a, addr_b;
  logic             idx_ok;

  // table read
  logic signed [31:0] wmem [TABLE_SAMPLES];
  logic signed [31:0] gmem [TABLE_SAMPLES];
  logic               vt;
  item_t              itt;
  logic               inside_t, qz_t;
  logic [15:0]        lam_t;
  logic signed [31:0] wa, wb, ga, gb;

  // interpolation
  logic signed [32:0] dw, dg;
  logic               vi1, inside_i1, qz_i1;
  item_t              iti1;
  logic signed [49:0] pw, pg;
  logic signed [31:0] wa1, ga1;
  logic               vi2, inside_i2, qz_i2;
  item_t              iti2;
  logic signed [31:0] sw, sg;

  // gradient products
  logic               vg, inside_g, qz_g;
  logic signed [31:0] swg;
  logic signed [63:0] pgx, pgy, pgz;

  // output
  logic               out_inside, out_qz;

  function automatic logic signed [31:0] sat_q16(input logic signed [63:0] p);
    logic signed [47:0] s;
    s = 48'(p >>> 16);
    if (s > 48'sd2147483647) return 32'sh7fffffff;
    if (s < -48'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  // whole pipeline moves when the output register can take a beat
  assign en      = !o_valid || o_ready;
  assign q_ready = en;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      svl[0]  <= 1'b0;
      vm      <= 1'b0;
      vq      <= 1'b0;
      vt      <= 1'b0;
      vi1     <= 1'b0;
      vi2     <= 1'b0;
      vg      <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      v1      <= q_valid;
      svl[0]  <= v1;
      vm      <= svl[SQRT_STEPS];
      vq      <= vm;
      vt      <= vq && (itq.cmd == CMD_EVAL);
      vi1     <= vt;
      vi2     <= vi1;
      vg      <= vi2;
      o_valid <= vg;
    end
  end

  // squares of the components
  always_ff @(posedge clk) begin
    if (en) begin
      it1 <= q_item;
      sq0 <= q_item.rx * q_item.rx;
      sq1 <= q_item.ry * q_item.ry;
      sq2 <= q_item.rz * q_item.rz;
    end
  end

  // sum of squares feeds the root
  always_ff @(posedge clk) begin
    if (en) begin
      sit[0] <= it1;
      sv[0]  <= $unsigned(sq0) + $unsigned(sq1) + $unsigned(sq2);
      sr[0]  <= '0;
    end
  end

  // restoring square root, one bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = sr[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        svl[k+1] <= 1'b0;
      end else if (en) begin
        svl[k+1] <= svl[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sit[k+1] <= sit[k];
        if (sv[k] >= trial) begin
          sv[k+1] <= sv[k] - trial;
          sr[k+1] <= (sr[k] >> 1) + BIT;
        end else begin
          sv[k+1] <= sv[k];
          sr[k+1] <= sr[k] >> 1;
        end
      end
    end
  end

  // length times inverse radius
  always_ff @(posedge clk) begin
    if (en) begin
      itm  <= sit[SQRT_STEPS];
      prod <= 64'(sr[SQRT_STEPS][31:0]) * 64'(inv_radius);
    end
  end

  // q and table position
  assign big   = prod[63:16];
  assign pos_c = POS_W'(big[16:0]) * POS_W'(TABLE_SAMPLES - 1);

  always_ff @(posedge clk) begin
    if (en) begin
      itq      <= itm;
      inside_q <= big <= 48'(Q_ONE);
      qz_q     <= big == '0;
      lo_q     <= pos_c[POS_W-1:16];
      lam_q    <= pos_c[15:0];
    end
  end

  // neighbor addresses, both pinned to the last entry on clamp
  assign clamp_q = lo_q >= LO_W'(TABLE_SAMPLES - 1);
  assign addr_a  = clamp_q ? IDX_W'(TABLE_SAMPLES - 1) : lo_q[IDX_W-1:0];
  assign addr_b  = clamp_q ? IDX_W'(TABLE_SAMPLES - 1) : lo_q[IDX_W-1:0] + 1'b1;
  assign idx_ok  = 32'(itq.entry_index) < 32'(TABLE_SAMPLES);

  // kernel table: load beats write, eval beats read two neighbors
  always_ff @(posedge clk) begin
    if (en) begin
      wa <= wmem[addr_a];
      wb <= wmem[addr_b];
      if (vq && itq.cmd == CMD_WLOAD && idx_ok) begin
        wmem[IDX_W'(itq.entry_index)] <= itq.entry_value;
      end
    end
  end

  // gradient table
  always_ff @(posedge clk) begin
    if (en) begin
      ga <= gmem[addr_a];
      gb <= gmem[addr_b];
      if (vq && itq.cmd == CMD_GLOAD && idx_ok) begin
        gmem[IDX_W'(itq.entry_index)] <= itq.entry_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      itt      <= itq;
      inside_t <= inside_q;
      qz_t     <= qz_q;
      lam_t    <= lam_q;
    end
  end

  // interpolation weight times neighbor difference
  assign dw = 33'(wb) - 33'(wa);
  assign dg = 33'(gb) - 33'(ga);

  always_ff @(posedge clk) begin
    if (en) begin
      iti1      <= itt;
      inside_i1 <= inside_t;
      qz_i1     <= qz_t;
      wa1       <= wa;
      ga1       <= ga;
      pw        <= $signed({1'b0, lam_t}) * dw;
      pg        <= $signed({1'b0, lam_t}) * dg;
    end
  end

  // floor of the fraction, added to the lower entry
  always_ff @(posedge clk) begin
    if (en) begin
      iti2      <= iti1;
      inside_i2 <= inside_i1;
      qz_i2     <= qz_i1;
      sw        <= wa1 + 32'(pw >>> 16);
      sg        <= ga1 + 32'(pg >>> 16);
    end
  end

  // gradient sample scales the vector
  always_ff @(posedge clk) begin
    if (en) begin
      inside_g <= inside_i2;
      qz_g     <= qz_i2;
      swg      <= sw;
      pgx      <= sg * iti2.rx;
      pgy      <= sg * iti2.ry;
      pgz      <= sg * iti2.rz;
    end
  end

  // output register with support and zero-length masking
  always_ff @(posedge clk) begin
    if (en) begin
      out_inside <= inside_g;
      out_qz     <= qz_g;
      w_value    <= inside_g ? swg : '0;
      grad_x     <= (inside_g && !qz_g) ? sat_q16(pgx) : '0;
      grad_y     <= (inside_g && !qz_g) ? sat_q16(pgy) : '0;
      grad_z     <= (inside_g && !qz_g) ? sat_q16(pgz) : '0;
    end
  end

  `SKTS_ASSERT_IMPL(a_outside_zero, o_valid && !out_inside, w_value == 0 && grad_x == 0 && grad_y == 0 && grad_z == 0, "nonzero result outside support")
  `SKTS_ASSERT_IMPL(a_zero_len_grad, o_valid && out_qz, grad_x == 0 && grad_y == 0 && grad_z == 0, "nonzero gradient at zero length")
  `SKTS_ASSERT_IMPL(a_clamp_last, vq && inside_q && clamp_q, lo_q == LO_W'(TABLE_SAMPLES - 1), "clamp inside support past last entry")
  `SKTS_ASSERT_NEXT(a_pop_enters, q_valid && q_ready, v1, "popped beat lost at pipeline entry")

endmodule

### hdl/sph_kernel_table_sampler.sv
// path: front holding stage, then queue, then back pipeline with the one-bit-per-stage
//   square root
// throughput: one beat per cycle; the back pipeline advances whenever the output
//   register is free or being taken
// reset: synchronous; clears valid bits, queue pointers, inv_radius to 1.0
//   table contents are not cleared and must be loaded before use
module sph_kernel_table_sampler import skts_pkg::*; (
  input logic           clk,
  input logic           rst,
  skts_item_if.sink     items,
  skts_result_if.source results,
  skts_cfg_if.sink      cfg
);

  logic        cfg_write;
  logic [31:0] inv_radius;
  logic        push_valid, push_ready, pop_valid, pop_ready;
  item_t       push_data, pop_data;

  // config register, always writable
  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_radius <= 32'(Q_ONE);
    end else if (cfg_write) begin
      inv_radius <= cfg.data;
    end
  end

  skts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  skts_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  skts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .inv_radius (inv_radius),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .q_item     (pop_data),
    .o_valid    (results.valid),
    .o_ready    (results.ready),
    .w_value    (results.w_value),
    .grad_x     (results.grad_x),
    .grad_y     (results.grad_y),
    .grad_z     (results.grad_z)
  );

endmodule

### sim/skts_tb_if.sv
// the bench drives and watches the block through the channel interfaces of the block

### sim/skts_kernel_checker.sv
// watches item and result beats, predicts kernel samples, compares in order
module skts_kernel_checker import skts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  skts_item_if      items,
  skts_result_if    results,
  skts_cfg_if       cfg,
  output int        fail_count,
  output int        pending
);

  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] gz;
  } sample_t;

  logic signed [31:0] kern_tab [TABLE_SAMPLES];
  logic signed [31:0] grad_tab [TABLE_SAMPLES];
  logic [31:0]        inv_rad;
  sample_t            want_q[$];
  int                 errs;

  // floor division by 65536
  function automatic longint fdiv16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint interp(bit use_grad, logic [63:0] q);
    logic [63:0] pos;
    logic [63:0] lo;
    longint      lam;
    longint      a;
    longint      b;
    pos = q * (TABLE_SAMPLES - 1);
    lo = pos >> 16;
    lam = longint'(pos & 64'hFFFF);
    if (lo >= TABLE_SAMPLES - 1)
      return use_grad ? grad_tab[TABLE_SAMPLES-1] : kern_tab[TABLE_SAMPLES-1];
    a = use_grad ? grad_tab[lo] : kern_tab[lo];
    b = use_grad ? grad_tab[lo+1] : kern_tab[lo+1];
    return a + fdiv16(lam * (b - a));
  endfunction

  function automatic sample_t predict_sample(longint x, longint y, longint z);
    sample_t     s;
    logic [63:0] len;
    logic [63:0] q;
    longint      g;
    s = '0;
    len = root64(64'(x * x) + 64'(y * y) + 64'(z * z));
    q = (len * {32'd0, inv_rad}) >> 16;
    if (q <= Q_ONE) begin
      s.w = 32'(interp(1'b0, q));
      if (q != 0) begin
        g = interp(1'b1, q);
        s.gx = 32'(clip32(fdiv16(g * x)));
        s.gy = 32'(clip32(fdiv16(g * y)));
        s.gz = 32'(clip32(fdiv16(g * z)));
      end
    end
    return s;
  endfunction

  assign fail_count = errs;

  // track beats on all three channels
  always @(posedge clk) begin
    sample_t got;
    sample_t exp_s;
    if (rst) begin
      inv_rad <= 32'd65536;
      want_q.delete();
      errs <= 0;
    end else begin
      if (cfg.valid && cfg.ready) inv_rad <= cfg.data;
      if (items.valid && items.ready) begin
        case (cmd_t'(items.cmd))
          CMD_EVAL:  want_q.push_back(predict_sample(items.rx, items.ry, items.rz));
          CMD_WLOAD: kern_tab[items.entry_index] <= items.entry_value;
          CMD_GLOAD: grad_tab[items.entry_index] <= items.entry_value;
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        got = {results.w_value, results.grad_x, results.grad_y, results.grad_z};
        if (want_q.size() == 0) begin
          errs <= errs + 1;
          if (errs < 10) $display("unexpected result beat %h", got);
        end else begin
          exp_s = want_q.pop_front();
          if (got !== exp_s) begin
            errs <= errs + 1;
            if (errs < 10)
              $display("result mismatch: exp w=%h g=%h %h %h got w=%h g=%h %h %h",
                       exp_s.w, exp_s.gx, exp_s.gy, exp_s.gz,
                       got.w, got.gx, got.gy, got.gz);
          end
        end
      end
    end
    pending <= want_q.size();
  end

endmodule

### sim/tb_sph_kernel_table_sampler.sv
module tb_sph_kernel_table_sampler;
  import skts_pkg::*;

  // loaded table entries: 0 to LOW_LOADED-1 and HIGH_LOADED to the last
  localparam int LOW_LOADED  = 64;
  localparam int HIGH_LOADED = 864;

  logic        clk;
  logic        rst;
  int          fail_count;
  int          pending;
  int          src_idle_pct;
  int          snk_idle_pct;
  bit          hold_off;
  logic [31:0] cur_radius;

  skts_item_if   items ();
  skts_result_if results ();
  skts_cfg_if    cfg ();

  sph_kernel_table_sampler dut (.clk(clk), .rst(rst), .items(items), .results(results),
                                .cfg(cfg));

  skts_kernel_checker chk (.clk(clk), .rst(rst), .items(items), .results(results),
                           .cfg(cfg), .fail_count(fail_count), .pending(pending));

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver ready, random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (rst || hold_off) results.ready <= 1'b0;
    else results.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // true when an evaluate beat only reads loaded table entries
  function automatic bit reads_loaded(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    longint      sx;
    longint      sy;
    longint      sz;
    logic [63:0] len;
    logic [63:0] q;
    logic [63:0] lo;
    sx = longint'($signed(x));
    sy = longint'($signed(y));
    sz = longint'($signed(z));
    len = root64(64'(sx * sx) + 64'(sy * sy) + 64'(sz * sz));
    q = (len * {32'd0, cur_radius}) >> 16;
    if (q > 64'(Q_ONE)) return 1'b1;
    lo = (q * 64'(TABLE_SAMPLES - 1)) >> 16;
    return (lo < 64'(LOW_LOADED - 1)) || (lo >= 64'(HIGH_LOADED));
  endfunction

  // one beat on the item channel, with random idle before it
  task automatic send_item(cmd_t c, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [9:0] ix, logic [31:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      items.valid = 1'b0;
      @(negedge clk);
    end
    items.valid = 1'b1;
    items.cmd = c;
    items.rx = x;
    items.ry = y;
    items.rz = z;
    items.entry_index = ix;
    items.entry_value = v;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
    @(negedge clk);
    items.valid = 1'b0;
  endtask

  task automatic eval_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_item(CMD_EVAL, x, y, z, 10'($urandom), $urandom);
  endtask

  // wait for all results, let the pipeline drain, then write the new radius
  task automatic set_radius(logic [31:0] v);
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg.valid = 1'b1;
    cfg.data = v;
    cur_radius = v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // vector with length spread over the support, kept on loaded entries
  task automatic rand_eval();
    int          sel;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    do begin
      sel = $urandom_range(9);
      if (sel < 6) begin
        x = $signed($urandom) >>> $urandom_range(31, 14);
        y = $signed($urandom) >>> $urandom_range(31, 14);
        z = $signed($urandom) >>> $urandom_range(31, 14);
      end else if (sel < 9) begin
        x = $urandom;
        y = $urandom;
        z = $urandom;
      end else begin
        x = '0;
        y = '0;
        z = '0;
      end
    end while (!reads_loaded(x, y, z));
    eval_vec(x, y, z);
  endtask

  initial begin
    int   ph;
    cmd_t c;
    hold_off = 0;
    src_idle_pct = 14;
    snk_idle_pct = 46;
    cur_radius = 32'h00010000;
    rst = 1;
    items.valid = 0;
    items.cmd = CMD_EVAL;
    items.rx = 0;
    items.ry = 0;
    items.rz = 0;
    items.entry_index = 0;
    items.entry_value = 0;
    cfg.valid = 0;
    cfg.data = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // load both ends of both tables, extremes at the edges
    for (int i = 0; i < TABLE_SAMPLES; i++) begin
      if (i < LOW_LOADED || i >= HIGH_LOADED) begin
        send_item(CMD_WLOAD, $urandom, $urandom, $urandom, i[9:0],
                  i == 0 ? 32'h7FFFFFFF : (i == 1 ? 32'h80000000 : $urandom));
        send_item(CMD_GLOAD, $urandom, $urandom, $urandom, i[9:0],
                  i == TABLE_SAMPLES - 1 ? 32'h80000000 : (i == 2 ? 32'h7FFFFFFF : $urandom));
      end
    end

    // directed: zero vector, unit, edges, clamp, outside support, ignored command
    eval_vec(0, 0, 0);
    eval_vec(32'h00010000, 0, 0);
    eval_vec(0, 32'hFFFF0000, 0);
    eval_vec(0, 0, 32'h0000FFFF);
    eval_vec(32'h00000001, 0, 0);
    eval_vec(32'h7FFFFFFF, 0, 0);
    eval_vec(32'h80000000, 32'h80000000, 32'h80000000);
    eval_vec(32'h00000800, 32'hFFFFF800, 32'h00000400);
    send_item(CMD_NONE, 32'h12345678, 0, 0, 0, 0);
    set_radius(32'h0);
    eval_vec(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    set_radius(32'hFFFFFFFF);
    eval_vec(32'h00000001, 0, 0);
    eval_vec(0, 0, 32'h00000001);
    eval_vec(32'h00000010, 32'h00000010, 0);
    set_radius(32'h00000001);
    eval_vec(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    set_radius(32'h00020000);
    eval_vec(32'h00008000, 0, 0);
    eval_vec(32'h00007FFF, 0, 0);
    eval_vec(32'hFFFF0000, 32'h7FFFFFFF, 0);

    // hold off the receiver so the pipeline fills and backs up
    fork
      begin
        hold_off = 1;
        repeat (200) @(negedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 80; i++) rand_eval();
    join

    // random phases: three idle profiles, several radii
    for (ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 14 : (ph == 1 ? 46 : 0);
      snk_idle_pct = (ph == 0) ? 46 : (ph == 1 ? 14 : 0);
      set_radius(ph == 0 ? 32'h00010000 : (ph == 1 ? 32'h00000400 : $urandom));
      for (int i = 0; i < 85; i++) begin
        if ($urandom_range(9) == 0) begin
          c = cmd_t'($urandom_range(3));
          if (c == CMD_EVAL) rand_eval();
          else send_item(c, $urandom, $urandom, $urandom, 10'($urandom), $urandom);
        end else rand_eval();
      end
    end

    // drain
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
